FILE: rtl/dsp_pkg.sv
// Shared constants, types and helpers of the dense shortest path engine.
package dsp_pkg;

	// Sizing of the weight store and the distance table
	localparam int MAX_NODES     = 16;
	localparam int WEIGHT_BITS   = 16;
	localparam int NODE_BITS     = $clog2(MAX_NODES);
	localparam int MAT_DEPTH     = MAX_NODES * MAX_NODES;
	localparam int MAT_ADDR_BITS = 2 * NODE_BITS;

	// Port field widths
	localparam int IDX_BITS  = 6;
	localparam int CNT_BITS  = 7;
	localparam int WIN_BITS  = 16;
	localparam int DIST_BITS = 24;

	// Path sums carry one bit beyond the wider operand before saturation
	localparam int SUM_BITS = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;
	localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

	// Configuration registers
	localparam int ADDR_BITS = 3;
	localparam logic REG_NODE_COUNT = 1'b0;
	localparam logic REG_START_NODE = 1'b1;
	localparam logic [CNT_BITS-1:0] NODE_COUNT_RST = 7'd16;
	localparam logic [IDX_BITS-1:0] START_NODE_RST = 6'd0;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic                 load;       // store the accepted matrix entry
		logic                 init;       // open all nodes, seed the start node
		logic                 scan;       // compare node idx against the running minimum
		logic                 pick;       // close the selected node
		logic                 relax;      // issue a weight read for row best, column idx
		logic                 emit;       // load the result for node idx
		logic                 emit_last;  // node idx is the final node
		logic                 clear;      // drop every stored edge
		logic [NODE_BITS-1:0] idx;
	} dsp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic found;     // an open reached node was seen in the last scan
		logic out_free;  // the result register can take a new result
	} dsp_sts_t;

	// Fit an input weight to the stored weight width
	function automatic logic [WEIGHT_BITS-1:0] wt_fit(input logic [WIN_BITS-1:0] w);
		logic [WEIGHT_BITS-1:0] r;
		r = '0;
		for (int b = 0; b < WEIGHT_BITS; b++) begin
			r[b] = (b < WIN_BITS) ? w[b] : 1'b0;
		end
		return r;
	endfunction

endpackage

FILE: rtl/dsp_wmem.sv
// Weight matrix store with per-entry valid bits and registered read.
module dsp_wmem import dsp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [MAT_ADDR_BITS-1:0] wr_addr,
	input  logic [WEIGHT_BITS-1:0]   wr_data,
	input  logic                     rd_en,
	input  logic [MAT_ADDR_BITS-1:0] rd_addr,
	input  logic                     clr,
	output logic [WEIGHT_BITS-1:0]   rd_data
);

	logic [WEIGHT_BITS-1:0] mem [MAT_DEPTH];
	logic [MAT_DEPTH-1:0]   vld_q;
	logic [WEIGHT_BITS-1:0] rd_data_q;
	logic                   rd_hit_q;

	// Write the array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Track which entries hold an edge since the last clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clr) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// Register the read data and its valid bit
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
			rd_hit_q  <= vld_q[rd_addr];
		end
	end

	// An entry never written since the last clear reads as no edge
	assign rd_data = rd_hit_q ? rd_data_q : '0;

endmodule

FILE: rtl/dsp_datapath.sv
// Datapath: weight store, distance table, minimum scan, relaxation and result register.
module dsp_datapath import dsp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dsp_cmd_t             cmd,
	output dsp_sts_t             sts,
	input  logic [NODE_BITS-1:0] start_idx,
	input  logic                 start_ok,
	input  logic [IDX_BITS-1:0]  row_node,
	input  logic [IDX_BITS-1:0]  col_node,
	input  logic [WIN_BITS-1:0]  edge_weight,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [IDX_BITS-1:0]  node_index,
	output logic [DIST_BITS-1:0] distance,
	output logic                 reachable,
	output logic                 last_node
);

	logic [DIST_BITS-1:0]     dist_q [MAX_NODES];
	logic [MAX_NODES-1:0]     reached_q;
	logic [MAX_NODES-1:0]     open_q;
	logic                     found_q;
	logic [NODE_BITS-1:0]     best_idx_q;
	logic [DIST_BITS-1:0]     best_d_q;
	logic                     relax_s1;
	logic [NODE_BITS-1:0]     idx_s1;
	logic                     out_valid_q;
	logic [IDX_BITS-1:0]      node_index_q;
	logic [DIST_BITS-1:0]     distance_q;
	logic                     reachable_q;
	logic                     last_node_q;
	logic                     entry_ok;
	logic [MAT_ADDR_BITS-1:0] wr_addr;
	logic [MAT_ADDR_BITS-1:0] rd_addr;
	logic [WEIGHT_BITS-1:0]   rd_w;
	logic [SUM_BITS-1:0]      sum;
	logic [DIST_BITS-1:0]     cand;
	logic                     improve;
	logic                     better;

	// Drop entries whose row or column lies beyond the store
	assign entry_ok = (CNT_BITS'(row_node) < CNT_BITS'(MAX_NODES))
		&& (CNT_BITS'(col_node) < CNT_BITS'(MAX_NODES));
	assign wr_addr = {row_node[NODE_BITS-1:0], col_node[NODE_BITS-1:0]};
	assign rd_addr = {best_idx_q, cmd.idx};

	dsp_wmem u_wmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd.load && entry_ok),
		.wr_addr (wr_addr),
		.wr_data (wt_fit(edge_weight)),
		.rd_en   (cmd.relax),
		.rd_addr (rd_addr),
		.clr     (cmd.clear),
		.rd_data (rd_w)
	);

	// Track the issued weight read in step with its registered read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relax_s1 <= 1'b0;
		end else begin
			relax_s1 <= cmd.relax;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cmd.idx;
	end

	// Form the saturated candidate distance through the selected node
	always_comb begin
		sum     = SUM_BITS'(best_d_q) + SUM_BITS'(rd_w);
		cand    = (sum > SUM_BITS'(DIST_MAX)) ? DIST_MAX : sum[DIST_BITS-1:0];
		improve = relax_s1 && (rd_w != '0)
			&& (!reached_q[idx_s1] || (cand < dist_q[idx_s1]));
	end

	// Compare the scanned node against the running minimum
	assign better = open_q[cmd.idx] && reached_q[cmd.idx]
		&& (!found_q || (dist_q[cmd.idx] < best_d_q));

	// Update the distance table
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			dist_q[start_idx] <= '0;
		end else if (improve) begin
			dist_q[idx_s1] <= cand;
		end
	end

	// Update reached and open flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reached_q <= '0;
			open_q    <= '1;
		end else if (cmd.init) begin
			reached_q <= MAX_NODES'(start_ok) << start_idx;
			open_q    <= '1;
		end else begin
			if (improve) begin
				reached_q[idx_s1] <= 1'b1;
			end
			if (cmd.pick) begin
				open_q[best_idx_q] <= 1'b0;
			end
		end
	end

	// Hold the running minimum of the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.init || cmd.pick) begin
			found_q <= 1'b0;
		end else if (cmd.scan && better) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan && better) begin
			best_idx_q <= cmd.idx;
			best_d_q   <= dist_q[cmd.idx];
		end
	end

	// Result register: load on emit, drop once the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			node_index_q <= IDX_BITS'(cmd.idx);
			distance_q   <= reached_q[cmd.idx] ? dist_q[cmd.idx] : '0;
			reachable_q  <= reached_q[cmd.idx];
			last_node_q  <= cmd.emit_last;
		end
	end

	assign sts.found    = found_q;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign node_index = node_index_q;
	assign distance   = distance_q;
	assign reachable  = reachable_q;
	assign last_node  = last_node_q;

endmodule

FILE: rtl/dsp_ctrl.sv
// Controller: sequences loading, minimum scans, relaxation rounds and result output.
module dsp_ctrl import dsp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 last_entry,
	input  logic [NODE_BITS-1:0] n_last,
	input  dsp_sts_t             sts,
	output dsp_cmd_t             cmd
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_INIT  = 7'b0000010,
		S_SCAN  = 7'b0000100,
		S_PICK  = 7'b0001000,
		S_RELAX = 7'b0010000,
		S_DRAIN = 7'b0100000,
		S_EMIT  = 7'b1000000
	} state_t;

	state_t               state_q, state_d;
	logic [NODE_BITS-1:0] idx_q, idx_d;
	logic                 at_last;

	assign at_last  = (idx_q == n_last);
	assign in_ready = (state_q == S_IDLE);

	// Decode next state and commands
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cmd     = '0;
		cmd.idx = idx_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (last_entry) begin
						state_d = S_INIT;
					end
				end
			end
			S_INIT: begin
				cmd.init = 1'b1;
				idx_d    = '0;
				state_d  = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (at_last) begin
					state_d = S_PICK;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			S_PICK: begin
				idx_d = '0;
				if (sts.found) begin
					cmd.pick = 1'b1;
					state_d  = S_RELAX;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_RELAX: begin
				cmd.relax = 1'b1;
				if (at_last) begin
					state_d = S_DRAIN;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			S_DRAIN: begin
				idx_d   = '0;
				state_d = S_SCAN;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_last = at_last;
					if (at_last) begin
						cmd.clear = 1'b1;
						state_d   = S_IDLE;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance state and node counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

endmodule

FILE: rtl/dense_shortest_path_engine.sv
// Top level of the dense shortest path engine: configuration registers and core wiring.
//
// Matrix entries (row_node, col_node, edge_weight) are taken one per transaction, one
// every cycle while loading; a zero weight means no edge and entries outside the store
// are dropped. The transaction with last_entry set starts a Dijkstra search from
// start_node over the first node_count nodes (clamped to 1..MAX_NODES). With n nodes in
// use, each round is a minimum scan over the n nodes, a pick of the selected node, a row
// read of its n weights from the weight store and a drain state, each scan or read step
// handling one node per cycle; there is one round per reachable node plus a final empty
// scan, after one setup state. Then n results stream out, one per cycle when out_ready
// stays high, and the weight store is emptied in the same cycle as the last result is
// loaded.
// No input is taken from the last entry until the final result is loaded.
module dense_shortest_path_engine import dsp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// Matrix entries
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [IDX_BITS-1:0]  row_node,
	input  logic [IDX_BITS-1:0]  col_node,
	input  logic [WIN_BITS-1:0]  edge_weight,
	input  logic                 last_entry,
	// Distance results
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [IDX_BITS-1:0]  node_index,
	output logic [DIST_BITS-1:0] distance,
	output logic                 reachable,
	output logic                 last_node
);

	logic [CNT_BITS-1:0]  node_count_q;
	logic [IDX_BITS-1:0]  start_node_q;
	logic [CNT_BITS-1:0]  n_used;
	logic [NODE_BITS-1:0] n_last;
	logic                 start_ok;
	logic                 wr_en;
	dsp_cmd_t             cmd;
	dsp_sts_t             sts;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
			start_node_q <= START_NODE_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_NODE_COUNT: node_count_q <= pwdata[CNT_BITS-1:0];
				REG_START_NODE: start_node_q <= pwdata[IDX_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		case (paddr[2])
			REG_NODE_COUNT: prdata = 32'(node_count_q);
			REG_START_NODE: prdata = 32'(start_node_q);
			default:        prdata = '0;
		endcase
	end

	// Clamp the node count and check the start node against it
	always_comb begin
		if (node_count_q == '0) begin
			n_used = CNT_BITS'(1);
		end else if (node_count_q > CNT_BITS'(MAX_NODES)) begin
			n_used = CNT_BITS'(MAX_NODES);
		end else begin
			n_used = node_count_q;
		end
		n_last   = NODE_BITS'(n_used - 1'b1);
		start_ok = CNT_BITS'(start_node_q) < n_used;
	end

	dsp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.last_entry (last_entry),
		.n_last     (n_last),
		.sts        (sts),
		.cmd        (cmd)
	);

	dsp_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.start_idx   (start_node_q[NODE_BITS-1:0]),
		.start_ok    (start_ok),
		.row_node    (row_node),
		.col_node    (col_node),
		.edge_weight (edge_weight),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.node_index  (node_index),
		.distance    (distance),
		.reachable   (reachable),
		.last_node   (last_node)
	);

endmodule
